### sv/assert_macros.svh
// Assertion helpers used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define RRJ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define RRJ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/rrj_pkg.sv
package rrj_pkg;

    localparam int IN_W     = 32;
    localparam int RAD_W    = 66;
    localparam int ROOT_W   = 33;
    localparam int SQREM_W  = 35;
    localparam int SQ_STEPS = 33;
    localparam int NUM_W    = 63;
    localparam int DEN_W    = 33;
    localparam int DVREM_W  = 34;
    localparam int QUO_W    = 32;
    localparam int DV_STEPS = 32;
    localparam int FRAC_SH  = 30;
    localparam int RNG_W    = 33;
    localparam int RES_W    = 34;
    // front stages, sqrt, finish stage, divide, output stage
    localparam int PIPE_DEPTH = 5 + SQ_STEPS + 1 + DV_STEPS + 1;

    // Count leading zeros of a 32-bit word.
    function automatic logic [4:0] clz32(input logic [31:0] v);
        logic [4:0] n;
        logic       found;
        n     = 5'd0;
        found = 1'b0;
        for (int i = 31; i >= 0; i--) begin
            if (!found && v[i]) begin
                n     = 5'(31 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

### sv/rrj_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module rrj_sqrt (
    input  logic                         clk,
    input  logic                         en,
    input  logic [rrj_pkg::RAD_W-1:0]    radicand,
    output logic [rrj_pkg::ROOT_W-1:0]   root,
    output logic [rrj_pkg::SQREM_W-1:0]  rem
);

    logic [rrj_pkg::RAD_W-1:0]   rad_reg  [rrj_pkg::SQ_STEPS-1];
    logic [rrj_pkg::ROOT_W-1:0]  root_reg [rrj_pkg::SQ_STEPS];
    logic [rrj_pkg::SQREM_W-1:0] rem_reg  [rrj_pkg::SQ_STEPS];

    for (genvar k = 0; k < rrj_pkg::SQ_STEPS; k++) begin : g_stage
        logic [rrj_pkg::RAD_W-1:0]   rad_in;
        logic [rrj_pkg::ROOT_W-1:0]  root_in;
        logic [rrj_pkg::SQREM_W-1:0] rem_in;
        logic [rrj_pkg::SQREM_W-1:0] r2;
        logic [rrj_pkg::SQREM_W-1:0] trial;
        logic                        ge;

        if (k == 0) begin : g_first
            assign rad_in  = radicand;
            assign root_in = '0;
            assign rem_in  = '0;
        end else begin : g_next
            assign rad_in  = rad_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rem_in  = rem_reg[k-1];
        end

        // bring down the next two radicand bits and try the next root bit
        assign r2    = {rem_in[rrj_pkg::SQREM_W-3:0], rad_in[rrj_pkg::RAD_W-1 -: 2]};
        assign trial = {root_in, 2'b01};
        assign ge    = (r2 >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[k] <= {root_in[rrj_pkg::ROOT_W-2:0], ge};
                rem_reg[k]  <= ge ? (r2 - trial) : r2;
            end
        end

        if (k < rrj_pkg::SQ_STEPS - 1) begin : g_rad
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[k] <= {rad_in[rrj_pkg::RAD_W-3:0], 2'b00};
                end
            end
        end
    end

    assign root = root_reg[rrj_pkg::SQ_STEPS-1];
    assign rem  = rem_reg[rrj_pkg::SQ_STEPS-1];

endmodule

### sv/rrj_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module rrj_div (
    input  logic                        clk,
    input  logic                        en,
    input  logic [rrj_pkg::NUM_W-1:0]   num,
    input  logic [rrj_pkg::DEN_W-1:0]   den,
    output logic [rrj_pkg::QUO_W-1:0]   quo
);

    logic [rrj_pkg::QUO_W-1:0]  low_reg [rrj_pkg::DV_STEPS-1];
    logic [rrj_pkg::DEN_W-1:0]  den_reg [rrj_pkg::DV_STEPS-1];
    logic [rrj_pkg::DEN_W-1:0]  rem_reg [rrj_pkg::DV_STEPS-1];
    logic [rrj_pkg::QUO_W-1:0]  quo_reg [rrj_pkg::DV_STEPS];

    for (genvar k = 0; k < rrj_pkg::DV_STEPS; k++) begin : g_stage
        logic [rrj_pkg::QUO_W-1:0]   low_in;
        logic [rrj_pkg::DEN_W-1:0]   den_in;
        logic [rrj_pkg::DEN_W-1:0]   rem_in;
        logic [rrj_pkg::QUO_W-1:0]   quo_in;
        logic [rrj_pkg::DVREM_W-1:0] r2;
        logic                        ge;

        if (k == 0) begin : g_first
            // top numerator bits already lie below the divisor
            assign low_in = num[rrj_pkg::QUO_W-1:0];
            assign den_in = den;
            assign rem_in = {2'b00, num[rrj_pkg::NUM_W-1:rrj_pkg::QUO_W]};
            assign quo_in = '0;
        end else begin : g_next
            assign low_in = low_reg[k-1];
            assign den_in = den_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        // shift in one numerator bit, subtract the divisor when it fits
        assign r2 = {rem_in, low_in[rrj_pkg::QUO_W-1]};
        assign ge = (r2 >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[k] <= {quo_in[rrj_pkg::QUO_W-2:0], ge};
            end
        end

        if (k < rrj_pkg::DV_STEPS - 1) begin : g_carry
            logic [rrj_pkg::DVREM_W-1:0] r_new;
            assign r_new = ge ? (r2 - {1'b0, den_in}) : r2;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    low_reg[k] <= {low_in[rrj_pkg::QUO_W-2:0], 1'b0};
                    den_reg[k] <= den_in;
                    rem_reg[k] <= r_new[rrj_pkg::DEN_W-1:0];
                end
            end
        end
    end

    assign quo = quo_reg[rrj_pkg::DV_STEPS-1];

endmodule

### sv/range_residual_and_jacobian_unit.sv
// Range residual and line-of-sight unit vector for a 2D range constraint.
// Takes one item per clock when the output is taken every clock; each result
// passes through 5 front stages (subtract, square, normalize and sum), 33
// square-root stages, one rounding stage, 32 divider stages and the output
// register. The range is the rounded length of second minus first in Q16.16,
// the residual is range minus measured range, and unit_x/unit_y are the unit
// vector in Q2.30 (the Jacobian for the second point; negate it for the
// first). Coincident points give a zero unit vector and raise degenerate. A
// stall on the output freezes the whole pipeline.
module range_residual_and_jacobian_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  first_x,
    input  logic signed [31:0]  first_y,
    input  logic signed [31:0]  second_x,
    input  logic signed [31:0]  second_y,
    input  logic [31:0]         measured_range,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [32:0]         range,
    output logic signed [33:0]  residual,
    output logic signed [31:0]  unit_x,
    output logic signed [31:0]  unit_y,
    output logic                degenerate
);

    typedef struct packed {
        logic [31:0] meas;
        logic        deg;
        logic        sx;
        logic        sy;
        logic [31:0] axs;
        logic [31:0] ays;
    } sq_side_t;

    typedef struct packed {
        logic [rrj_pkg::RNG_W-1:0] rng;
        logic [rrj_pkg::RES_W-1:0] res;
        logic                      deg;
        logic                      sx;
        logic                      sy;
    } dv_side_t;

    logic en;
    logic vld_reg [rrj_pkg::PIPE_DEPTH];

    // stage 1: differences and magnitudes
    logic [32:0] dx, dy;
    logic [32:0] adx, ady;
    logic [31:0] ax1_reg, ay1_reg, meas1_reg;
    logic        sx1_reg, sy1_reg;
    // stage 2: squares and shift count
    logic [63:0] a2_reg, b2_reg;
    logic [31:0] ax2_reg, ay2_reg, meas2_reg;
    logic [4:0]  sh2_reg;
    logic        sx2_reg, sy2_reg, deg2_reg;
    logic [31:0] m1;
    // stage 3: range sum, normalized magnitudes
    logic [64:0] sumr3_reg;
    logic [31:0] axs3_reg, ays3_reg, meas3_reg;
    logic        sx3_reg, sy3_reg, deg3_reg;
    // stage 4: squares of normalized magnitudes
    logic [63:0] sa4_reg, sb4_reg;
    logic [64:0] sumr4_reg;
    sq_side_t    side4_reg;
    // stage 5: normalized sum
    logic [64:0] sumu5_reg, sumr5_reg;
    sq_side_t    side5_reg;

    sq_side_t    sq_side_reg [rrj_pkg::SQ_STEPS];
    logic [rrj_pkg::ROOT_W-1:0]  root_r, root_u;
    logic [rrj_pkg::SQREM_W-1:0] rem_r, rem_u;

    // finish stage
    logic [rrj_pkg::RNG_W-1:0] rng_f;
    logic [rrj_pkg::DEN_W-1:0] den_f;
    logic [rrj_pkg::NUM_W-1:0] numx_f, numy_f;
    logic [rrj_pkg::NUM_W-1:0] numx_reg, numy_reg;
    logic [rrj_pkg::DEN_W-1:0] den_reg;
    dv_side_t                  dvf_reg;
    dv_side_t                  dv_side_reg [rrj_pkg::DV_STEPS];
    sq_side_t                  sq_last;
    logic [rrj_pkg::QUO_W-1:0] qx, qy;
    logic [rrj_pkg::QUO_W-1:0] qxc, qyc;
    dv_side_t                  dv_last;

    localparam logic [rrj_pkg::QUO_W-1:0] UNIT_ONE = rrj_pkg::QUO_W'(1) << rrj_pkg::FRAC_SH;

    // advance everything unless the output holds an untaken result
    assign en       = !vld_reg[rrj_pkg::PIPE_DEPTH-1] || out_ready;
    assign in_ready = en;

    // move valid bits along with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rrj_pkg::PIPE_DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < rrj_pkg::PIPE_DEPTH; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // stage 1: form the difference vector
    assign dx  = {second_x[31], second_x} - {first_x[31], first_x};
    assign dy  = {second_y[31], second_y} - {first_y[31], first_y};
    assign adx = dx[32] ? (33'd0 - dx) : dx;
    assign ady = dy[32] ? (33'd0 - dy) : dy;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax1_reg   <= adx[31:0];
            ay1_reg   <= ady[31:0];
            sx1_reg   <= dx[32];
            sy1_reg   <= dy[32];
            meas1_reg <= measured_range;
        end
    end

    // stage 2: square magnitudes, find the normalizing shift
    assign m1 = (ax1_reg > ay1_reg) ? ax1_reg : ay1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a2_reg    <= 64'(ax1_reg) * 64'(ax1_reg);
            b2_reg    <= 64'(ay1_reg) * 64'(ay1_reg);
            sh2_reg   <= rrj_pkg::clz32(m1);
            deg2_reg  <= (m1 == 32'd0);
            ax2_reg   <= ax1_reg;
            ay2_reg   <= ay1_reg;
            sx2_reg   <= sx1_reg;
            sy2_reg   <= sy1_reg;
            meas2_reg <= meas1_reg;
        end
    end

    // stage 3: sum squares, normalize magnitudes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sumr3_reg <= {1'b0, a2_reg} + {1'b0, b2_reg};
            axs3_reg  <= ax2_reg << sh2_reg;
            ays3_reg  <= ay2_reg << sh2_reg;
            sx3_reg   <= sx2_reg;
            sy3_reg   <= sy2_reg;
            deg3_reg  <= deg2_reg;
            meas3_reg <= meas2_reg;
        end
    end

    // stage 4: square normalized magnitudes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa4_reg        <= 64'(axs3_reg) * 64'(axs3_reg);
            sb4_reg        <= 64'(ays3_reg) * 64'(ays3_reg);
            sumr4_reg      <= sumr3_reg;
            side4_reg.meas <= meas3_reg;
            side4_reg.deg  <= deg3_reg;
            side4_reg.sx   <= sx3_reg;
            side4_reg.sy   <= sy3_reg;
            side4_reg.axs  <= axs3_reg;
            side4_reg.ays  <= ays3_reg;
        end
    end

    // stage 5: normalized sum of squares
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sumu5_reg <= {1'b0, sa4_reg} + {1'b0, sb4_reg};
            sumr5_reg <= sumr4_reg;
            side5_reg <= side4_reg;
        end
    end

    rrj_sqrt u_sqrt_range (
        .clk      (clk),
        .en       (en),
        .radicand ({1'b0, sumr5_reg}),
        .root     (root_r),
        .rem      (rem_r)
    );

    rrj_sqrt u_sqrt_unit (
        .clk      (clk),
        .en       (en),
        .radicand ({1'b0, sumu5_reg}),
        .root     (root_u),
        .rem      (rem_u)
    );

    // hold side data alongside the square roots
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_side_reg[0] <= side5_reg;
            for (int i = 1; i < rrj_pkg::SQ_STEPS; i++)
            begin
                sq_side_reg[i] <= sq_side_reg[i-1];
            end
        end
    end

    assign sq_last = sq_side_reg[rrj_pkg::SQ_STEPS-1];

    // finish: round the range, build the divider operands
    assign rng_f  = root_r + rrj_pkg::RNG_W'(rem_r > {2'b00, root_r});
    assign den_f  = (root_u == '0) ? rrj_pkg::DEN_W'(1) : root_u;
    assign numx_f = {1'b0, sq_last.axs, 30'd0} + rrj_pkg::NUM_W'(den_f >> 1);
    assign numy_f = {1'b0, sq_last.ays, 30'd0} + rrj_pkg::NUM_W'(den_f >> 1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            numx_reg    <= numx_f;
            numy_reg    <= numy_f;
            den_reg     <= den_f;
            dvf_reg.rng <= rng_f;
            dvf_reg.res <= {1'b0, rng_f} - {2'b00, sq_last.meas};
            dvf_reg.deg <= sq_last.deg;
            dvf_reg.sx  <= sq_last.sx;
            dvf_reg.sy  <= sq_last.sy;
        end
    end

    rrj_div u_div_x (
        .clk (clk),
        .en  (en),
        .num (numx_reg),
        .den (den_reg),
        .quo (qx)
    );

    rrj_div u_div_y (
        .clk (clk),
        .en  (en),
        .num (numy_reg),
        .den (den_reg),
        .quo (qy)
    );

    // hold side data alongside the divides
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_side_reg[0] <= dvf_reg;
            for (int i = 1; i < rrj_pkg::DV_STEPS; i++)
            begin
                dv_side_reg[i] <= dv_side_reg[i-1];
            end
        end
    end

    assign dv_last = dv_side_reg[rrj_pkg::DV_STEPS-1];
    assign qxc     = (qx > UNIT_ONE) ? UNIT_ONE : qx;
    assign qyc     = (qy > UNIT_ONE) ? UNIT_ONE : qy;

    // output register: apply signs, zero the vector for coincident points
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            range      <= dv_last.rng;
            residual   <= dv_last.res;
            degenerate <= dv_last.deg;
            if (dv_last.deg)
            begin
                unit_x <= '0;
                unit_y <= '0;
            end
            else
            begin
                unit_x <= dv_last.sx ? (32'd0 - qxc) : qxc;
                unit_y <= dv_last.sy ? (32'd0 - qyc) : qyc;
            end
        end
    end

    assign out_valid = vld_reg[rrj_pkg::PIPE_DEPTH-1];

endmodule

### sv/rrj_checker.sv
`include "assert_macros.svh"

module rrj_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [32:0]         range,
    input logic signed [33:0]  residual,
    input logic signed [31:0]  unit_x,
    input logic signed [31:0]  unit_y,
    input logic                degenerate
);

    // hold a stalled result
    `RRJ_ASSERT(a_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(range) && $stable(residual) && $stable(unit_x) && $stable(unit_y), "stalled result changed")

    // empty output never blocks input
    `RRJ_ASSERT_ALWAYS(a_ready, clk, !out_valid |-> in_ready, "input blocked with empty output")

    // coincident points give zero length and zero vector
    `RRJ_ASSERT(a_degen, clk, rst_n, out_valid && degenerate |-> range == 33'd0 && unit_x == 32'sd0 && unit_y == 32'sd0, "degenerate result not zero")

    // distinct points give a nonzero length
    `RRJ_ASSERT(a_nonzero, clk, rst_n, out_valid && !degenerate |-> range != 33'd0, "zero range without degenerate flag")

    // unit components stay within one
    `RRJ_ASSERT(a_bound, clk, rst_n, out_valid |-> unit_x <= 32'sh40000000 && unit_x >= -32'sh40000000 && unit_y <= 32'sh40000000 && unit_y >= -32'sh40000000, "unit component out of range")

endmodule

bind range_residual_and_jacobian_unit rrj_checker u_rrj_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .range      (range),
    .residual   (residual),
    .unit_x     (unit_x),
    .unit_y     (unit_y),
    .degenerate (degenerate)
);

### bench/range_residual_and_jacobian_unit_tb.sv
module range_residual_and_jacobian_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 150;

    typedef struct packed {
        logic [32:0]        range;
        logic signed [33:0] residual;
        logic signed [31:0] unit_x;
        logic signed [31:0] unit_y;
        logic               degenerate;
    } range_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic [31:0]        measured_range;
    logic               out_valid;
    logic               out_ready;
    logic [32:0]        range;
    logic signed [33:0] residual;
    logic signed [31:0] unit_x;
    logic signed [31:0] unit_y;
    logic               degenerate;

    range_result_t pending_results[$];
    int            error_count;
    int            quiet_cycles;
    bit            steady_phase;

    range_residual_and_jacobian_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .first_x        (first_x),
        .first_y        (first_y),
        .second_x       (second_x),
        .second_y       (second_y),
        .measured_range (measured_range),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .range          (range),
        .residual       (residual),
        .unit_x         (unit_x),
        .unit_y         (unit_y),
        .degenerate     (degenerate)
    );

    always #2 clk = ~clk;

    // Floor square root of a value below 2^66
    function automatic logic [32:0] floor_root(input logic [65:0] v);
        logic [32:0] s;
        logic [32:0] t;
        logic [65:0] tw;
        s = '0;
        for (int k = 32; k >= 0; k--) begin
            t  = s | (33'd1 << k);
            tw = 66'(t);
            if (tw * tw <= v)
                s = t;
        end
        return s;
    endfunction

    // One Q2.30 component of the line-of-sight vector
    function automatic logic [31:0] unit_part(input logic [63:0] mag, input bit neg,
                                              input logic [63:0] n);
        logic [63:0] q;
        q = ((mag << 30) + (n >> 1)) / n;
        if (q > 64'd1073741824)
            q = 64'd1073741824;
        return neg ? 32'(-q) : q[31:0];
    endfunction

    // Expected range, residual and unit vector for one pair of points
    function automatic range_result_t range_and_unit_of(
        input logic signed [31:0] fx, input logic signed [31:0] fy,
        input logic signed [31:0] sx, input logic signed [31:0] sy,
        input logic [31:0] meas);
        range_result_t r;
        longint        dx;
        longint        dy;
        logic [63:0]   ax;
        logic [63:0]   ay;
        logic [63:0]   m;
        logic [65:0]   sum;
        logic [32:0]   s;
        logic [65:0]   sw;
        logic [33:0]   rng;
        logic [63:0]   n;
        dx  = longint'(sx) - longint'(fx);
        dy  = longint'(sy) - longint'(fy);
        ax  = dx < 0 ? -dx : dx;
        ay  = dy < 0 ? -dy : dy;
        sum = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
        s   = floor_root(sum);
        sw  = 66'(s);
        rng = 34'(s);
        if (sum - sw * sw > sw)
            rng = rng + 34'd1;
        r.range      = rng[32:0];
        r.residual   = 34'({1'b0, rng[32:0]}) - 34'(meas);
        r.unit_x     = '0;
        r.unit_y     = '0;
        r.degenerate = 1'b1;
        if (ax != 0 || ay != 0) begin
            m = ax > ay ? ax : ay;
            while (m < 64'h8000_0000) begin
                m  = m << 1;
                ax = ax << 1;
                ay = ay << 1;
            end
            sum = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
            n   = 64'(floor_root(sum));
            if (n == 0)
                n = 1;
            r.unit_x     = unit_part(ax, dx < 0, n);
            r.unit_y     = unit_part(ay, dy < 0, n);
            r.degenerate = 1'b0;
        end
        return r;
    endfunction

    // Offer one item, after a random gap outside the steady phase, and hold it until the transfer
    task automatic send_item(input logic signed [31:0] fx, input logic signed [31:0] fy,
                             input logic signed [31:0] sx, input logic signed [31:0] sy,
                             input logic [31:0] meas);
        while (!steady_phase && $urandom_range(0, 99) < 29) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        first_x        <= fx;
        first_y        <= fy;
        second_x       <= sx;
        second_y       <= sy;
        measured_range <= meas;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic test_extremes();
        send_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'h0);
        send_item(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  32'hFFFF_FFFF);
        send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                  32'h8000_0000);
        send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                  32'h7FFF_FFFF);
        send_item(32'sh0, 32'sh0, 32'sh0000_0001, 32'sh0, 32'h1);
        send_item(32'sh0, 32'sh0, 32'sh0000_0001, 32'sh0000_0001, 32'h2);
        send_item(32'sh1234_5678, 32'shEDCB_A987, 32'sh1234_5679, 32'shEDCB_A986, 32'h0);
    endtask

    task automatic test_coincident();
        send_item(32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'h0);
        send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                  32'hFFFF_FFFF);
        send_item(32'sh0001_0000, 32'shFFFF_0000, 32'sh0001_0000, 32'shFFFF_0000,
                  32'h0001_0000);
    endtask

    task automatic test_axes();
        // pure x, pure y, both signs, plus the 3-4-5 triangle
        send_item(32'sh0, 32'sh0, 32'sh0005_0000, 32'sh0, 32'h0005_0000);
        send_item(32'sh0, 32'sh0, 32'shFFFB_0000, 32'sh0, 32'h0004_0000);
        send_item(32'sh0, 32'sh0, 32'sh0, 32'sh0007_0000, 32'h0008_0000);
        send_item(32'sh0, 32'sh0, 32'sh0, 32'shFFF9_0000, 32'h0);
        send_item(32'sh0001_0000, 32'sh0001_0000, 32'sh0004_0000, 32'sh0005_0000,
                  32'h0005_0000);
        send_item(32'sh0004_0000, 32'sh0005_0000, 32'sh0001_0000, 32'sh0001_0000,
                  32'h0006_0000);
    endtask

    task automatic test_random(input int count);
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        int                 pick;
        for (int i = 0; i < count; i++) begin
            // long stretch with no idling on either side
            steady_phase = (i >= count / 3) && (i < count / 3 + 80);
            fx   = $urandom;
            fy   = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                sx = fx + $signed($urandom_range(0, 32'hFFFF)) - 32'sh8000;
                sy = fy + $signed($urandom_range(0, 32'hFFFF)) - 32'sh8000;
            end else if (pick < 90) begin
                sx = $urandom;
                sy = $urandom;
            end else if (pick < 95) begin
                sx = fx;
                sy = fy;
            end else begin
                sx = fx + $signed($urandom_range(0, 2)) - 1;
                sy = fy + $signed($urandom_range(0, 2)) - 1;
            end
            send_item(fx, fy, sx, sy, $urandom);
        end
        steady_phase = 1'b0;
    endtask

    // Predict on every input transfer
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready)
            pending_results.push_back(range_and_unit_of(first_x, first_y, second_x,
                                                        second_y, measured_range));
    end

    // Compare every output transfer with the oldest prediction
    always @(posedge clk) begin
        range_result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no expectation: range %h", $time, range);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (range !== want.range) begin
                    $display("%0t: range expected %h actual %h", $time, want.range, range);
                    error_count++;
                end
                if (residual !== want.residual) begin
                    $display("%0t: residual expected %h actual %h", $time, want.residual,
                             residual);
                    error_count++;
                end
                if (unit_x !== want.unit_x) begin
                    $display("%0t: unit_x expected %h actual %h", $time, want.unit_x, unit_x);
                    error_count++;
                end
                if (unit_y !== want.unit_y) begin
                    $display("%0t: unit_y expected %h actual %h", $time, want.unit_y, unit_y);
                    error_count++;
                end
                if (degenerate !== want.degenerate) begin
                    $display("%0t: degenerate expected %b actual %b", $time,
                             want.degenerate, degenerate);
                    error_count++;
                end
            end
        end
    end

    // Stall the output side at random
    always @(posedge clk) begin
        out_ready <= steady_phase || ($urandom_range(0, 99) >= 29);
    end

    // Abort when no transfer happens for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        out_ready      = 1'b0;
        first_x        = '0;
        first_y        = '0;
        second_x       = '0;
        second_y       = '0;
        measured_range = '0;
        error_count    = 0;
        quiet_cycles   = 0;
        steady_phase   = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_coincident();
        test_axes();
        test_random(500);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### range_residual_and_jacobian_unit.f
+incdir+sv
sv/rrj_pkg.sv
sv/rrj_sqrt.sv
sv/rrj_div.sv
sv/range_residual_and_jacobian_unit.sv
sv/rrj_checker.sv
bench/range_residual_and_jacobian_unit_tb.sv
